// File: src/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// shared types and codes of the preemptive priority scheduler
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int ID_W   = 16;
   localparam int BURST_W = 16;
   localparam int PRIO_W = 8;
   localparam int TIME_W = 32;

   // kind of request item, carried on req_tuser
   typedef enum logic {
      ACT_SUBMIT = 1'b0,
      ACT_TICK   = 1'b1
   } action_type;

   // kind of result item, carried on rsp_tuser
   typedef enum logic [1:0] {
      RS_ACCEPTED = 2'd0,
      RS_REJECTED = 2'd1,
      RS_SERVED   = 2'd2,
      RS_IDLE     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_SEARCH,
      CS_EXEC
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic latch;   // capture the request fields
      logic exec;    // apply the request to the queue and load the result
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;   // result register can take a new result this cycle
   } dp_stat_type;

endpackage

// File: src/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// ready queue of jobs served one slot per tick, lowest priority number first
// ----------------------------------------------------------------------------
// req channel: one transfer per request. req_tuser selects submit (0) or
//   tick (1); req_tdata carries the job fields used by a submit.
// rsp channel: exactly one transfer per request, in request order. rsp_tuser
//   gives the status (accepted, rejected, served, idle), rsp_tdata the served
//   job, its remaining burst, the finished flag and the time after the item.
// sequence: a submit goes from acceptance straight to the exec state; a tick
//   first waits in the search state through the register levels of the
//   minimum tree that compares the queued priorities (3 levels at 8 slots).
//   The exec state loads the result register as soon as it is free.
// request flow: one request at a time; the next can be taken in the cycle
//   after the result of the previous one is loaded.
// reset: queue emptied and time cleared to zero, no result pending.
// stall: the result register holds while rsp_tready is low; a new request
//   is still taken and worked on, and its result waits for the register.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler
   import pps_pkg::*;
#(
   parameter int SLOTS = 8   // queue depth, 2 to 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // process_id[15:0], burst_length[31:16], priority_req[39:32]
   input  logic        req_tuser,   // action[0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // served_id[15:0], remaining[31:16], finished[32],
                                    // slot_end_time[64:33], zero fill[71:65]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int LEVELS = $clog2(SLOTS);

   dp_cmd_type         dp_cmd;
   dp_stat_type        dp_stat;
   status_type         rsp_status;
   logic [ID_W-1:0]    rsp_id;
   logic [BURST_W-1:0] rsp_rem;
   logic               rsp_fin;
   logic [TIME_W-1:0]  rsp_time;

   // sequencer: accepts in idle, waits out the tree levels on a tick
   pps_ctrl #(
      .LEVELS (LEVELS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .dp_stat    (dp_stat),
      .dp_cmd     (dp_cmd)
   );

   // queue, minimum tree, time counter and result register
   pps_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .dp_cmd     (dp_cmd),
      .dp_stat    (dp_stat),
      .req_action (req_tuser),
      .req_id     (req_tdata[15:0]),
      .req_burst  (req_tdata[31:16]),
      .req_prio   (req_tdata[39:32]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_id     (rsp_id),
      .rsp_rem    (rsp_rem),
      .rsp_fin    (rsp_fin),
      .rsp_time   (rsp_time)
   );

   // pack the result fields, lowest field first
   assign rsp_tdata = {7'd0, rsp_time, rsp_fin, rsp_rem, rsp_id};
   assign rsp_tuser = rsp_status;

endmodule

// File: src/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// sequencer: accept, on a tick wait for the minimum search tree, then execute
// ----------------------------------------------------------------------------
module pps_ctrl
   import pps_pkg::*;
#(
   parameter int LEVELS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_action,
   output logic        req_tready,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd
);

   localparam int CNT_W = (LEVELS < 2) ? 1 : $clog2(LEVELS);

   ctrl_state_type state_ff, state_in;
   logic [CNT_W-1:0] srch_cnt_ff, srch_cnt_in;
   logic             srch_done;

   assign srch_done = (srch_cnt_ff == CNT_W'(LEVELS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_tvalid) begin
               state_in = (action_type'(req_action) == ACT_TICK) ? CS_SEARCH : CS_EXEC;
            end
         end
         CS_SEARCH: begin
            if (srch_done) begin
               state_in = CS_EXEC;
            end
         end
         CS_EXEC: begin
            if (dp_stat.out_free) begin
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready   = 1'b0;
      dp_cmd.latch = 1'b0;
      dp_cmd.exec  = 1'b0;
      srch_cnt_in  = '0;
      unique case (state_ff)
         CS_IDLE: begin
            req_tready   = 1'b1;
            dp_cmd.latch = req_tvalid;
         end
         CS_SEARCH: begin
            srch_cnt_in = srch_cnt_ff + CNT_W'(1);
         end
         CS_EXEC: begin
            dp_cmd.exec = dp_stat.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= CS_IDLE;
         srch_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         srch_cnt_ff <= srch_cnt_in;
      end
   end

endmodule

// File: src/pps_dpath.sv
// ----------------------------------------------------------------------------
// pps_dpath
// job queue registers, pipelined minimum tree, time counter, result register
// ----------------------------------------------------------------------------
module pps_dpath
   import pps_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         dp_cmd,
   output dp_stat_type        dp_stat,
   input  logic               req_action,
   input  logic [ID_W-1:0]    req_id,
   input  logic [BURST_W-1:0] req_burst,
   input  logic [PRIO_W-1:0]  req_prio,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output status_type         rsp_status,
   output logic [ID_W-1:0]    rsp_id,
   output logic [BURST_W-1:0] rsp_rem,
   output logic               rsp_fin,
   output logic [TIME_W-1:0]  rsp_time
);

   localparam int LEVELS = $clog2(SLOTS);
   localparam int NLEAF  = 2 ** LEVELS;
   localparam int IDX_W  = LEVELS;
   localparam int CNT_W  = $clog2(SLOTS + 1);

   // latched request
   action_type         act_ff;
   logic [ID_W-1:0]    pid_ff;
   logic [BURST_W-1:0] burst_ff;
   logic [PRIO_W-1:0]  prio_ff;

   // queue in arrival order, entry 0 oldest
   logic [ID_W-1:0]    q_id_ff   [SLOTS];
   logic [BURST_W-1:0] q_rem_ff  [SLOTS];
   logic [PRIO_W-1:0]  q_prio_ff [SLOTS];
   logic [ID_W-1:0]    q_id_in   [SLOTS];
   logic [BURST_W-1:0] q_rem_in  [SLOTS];
   logic [PRIO_W-1:0]  q_prio_in [SLOTS];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TIME_W-1:0]  time_ff, time_in;

   // tournament tree, node n has children 2n and 2n+1, leaves at NLEAF and up
   logic               node_vld [1:2*NLEAF-1];
   logic [PRIO_W-1:0]  node_pri [1:2*NLEAF-1];
   logic [IDX_W-1:0]   node_idx [1:2*NLEAF-1];
   logic [ID_W-1:0]    node_id  [1:2*NLEAF-1];
   logic [BURST_W-1:0] node_rem [1:2*NLEAF-1];
   logic               tr_vld_ff [1:NLEAF-1];
   logic [PRIO_W-1:0]  tr_pri_ff [1:NLEAF-1];
   logic [IDX_W-1:0]   tr_idx_ff [1:NLEAF-1];
   logic [ID_W-1:0]    tr_id_ff  [1:NLEAF-1];
   logic [BURST_W-1:0] tr_rem_ff [1:NLEAF-1];

   // result register
   logic               rsp_vld_ff;
   status_type         rsp_status_ff;
   logic [ID_W-1:0]    rsp_id_ff;
   logic [BURST_W-1:0] rsp_rem_ff;
   logic               rsp_fin_ff;
   logic [TIME_W-1:0]  rsp_time_ff;

   logic               is_tick, have_job, q_full, fin;
   logic [BURST_W-1:0] new_rem;
   logic [IDX_W-1:0]   best;
   logic [TIME_W-1:0]  time_next;

   assign dp_stat.out_free = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (dp_cmd.latch) begin
         act_ff   <= action_type'(req_action);
         pid_ff   <= req_id;
         burst_ff <= req_burst;
         prio_ff  <= req_prio;
      end
   end

   // leaves
   for (genvar k = 0; k < NLEAF; k++) begin : g_leaf
      if (k < SLOTS) begin : g_real
         assign node_vld[NLEAF+k] = CNT_W'(k) < count_ff;
         assign node_pri[NLEAF+k] = q_prio_ff[k];
         assign node_id[NLEAF+k]  = q_id_ff[k];
         assign node_rem[NLEAF+k] = q_rem_ff[k];
      end else begin : g_pad
         assign node_vld[NLEAF+k] = 1'b0;
         assign node_pri[NLEAF+k] = '0;
         assign node_id[NLEAF+k]  = '0;
         assign node_rem[NLEAF+k] = '0;
      end
      assign node_idx[NLEAF+k] = IDX_W'(k);
   end

   // internal nodes, one register level per tree level; left wins a tie
   for (genvar n = 1; n < NLEAF; n++) begin : g_node
      logic take_r;
      assign take_r = node_vld[2*n+1] &&
                      (!node_vld[2*n] || (node_pri[2*n+1] < node_pri[2*n]));
      always_ff @(posedge clock) begin
         tr_vld_ff[n] <= node_vld[2*n] || node_vld[2*n+1];
         tr_pri_ff[n] <= take_r ? node_pri[2*n+1] : node_pri[2*n];
         tr_idx_ff[n] <= take_r ? node_idx[2*n+1] : node_idx[2*n];
         tr_id_ff[n]  <= take_r ? node_id[2*n+1]  : node_id[2*n];
         tr_rem_ff[n] <= take_r ? node_rem[2*n+1] : node_rem[2*n];
      end
      assign node_vld[n] = tr_vld_ff[n];
      assign node_pri[n] = tr_pri_ff[n];
      assign node_idx[n] = tr_idx_ff[n];
      assign node_id[n]  = tr_id_ff[n];
      assign node_rem[n] = tr_rem_ff[n];
   end

   assign is_tick   = (act_ff == ACT_TICK);
   assign have_job  = node_vld[1];
   assign best      = node_idx[1];
   assign new_rem   = (node_rem[1] == '0) ? '0 : node_rem[1] - BURST_W'(1);
   assign fin       = (new_rem == '0);
   assign q_full    = (count_ff == CNT_W'(SLOTS));
   assign time_next = (time_ff == '1) ? time_ff : time_ff + TIME_W'(1);

   // queue next values
   always_comb begin
      count_in = count_ff;
      time_in  = time_ff;
      for (int k = 0; k < SLOTS; k++) begin
         q_id_in[k]   = q_id_ff[k];
         q_rem_in[k]  = q_rem_ff[k];
         q_prio_in[k] = q_prio_ff[k];
      end
      if (dp_cmd.exec) begin
         if (!is_tick) begin
            if (!q_full) begin
               for (int k = 0; k < SLOTS; k++) begin
                  if (CNT_W'(k) == count_ff) begin
                     q_id_in[k]   = pid_ff;
                     q_rem_in[k]  = burst_ff;
                     q_prio_in[k] = prio_ff;
                  end
               end
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            time_in = time_next;
            if (have_job) begin
               if (!fin) begin
                  for (int k = 0; k < SLOTS; k++) begin
                     if (IDX_W'(k) == best) begin
                        q_rem_in[k] = new_rem;
                     end
                  end
               end else begin
                  // close the gap, later jobs move up one place
                  for (int k = 0; k < SLOTS - 1; k++) begin
                     if (IDX_W'(k) >= best) begin
                        q_id_in[k]   = q_id_ff[k+1];
                        q_rem_in[k]  = q_rem_ff[k+1];
                        q_prio_in[k] = q_prio_ff[k+1];
                     end
                  end
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SLOTS; k++) begin
         q_id_ff[k]   <= q_id_in[k];
         q_rem_ff[k]  <= q_rem_in[k];
         q_prio_ff[k] <= q_prio_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         time_ff  <= '0;
      end else begin
         count_ff <= count_in;
         time_ff  <= time_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (dp_cmd.exec) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.exec) begin
         rsp_id_ff   <= '0;
         rsp_rem_ff  <= '0;
         rsp_fin_ff  <= 1'b0;
         rsp_time_ff <= time_in;
         if (!is_tick) begin
            rsp_status_ff <= q_full ? RS_REJECTED : RS_ACCEPTED;
         end else if (!have_job) begin
            rsp_status_ff <= RS_IDLE;
         end else begin
            rsp_status_ff <= RS_SERVED;
            rsp_id_ff     <= node_id[1];
            rsp_rem_ff    <= new_rem;
            rsp_fin_ff    <= fin;
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_id     = rsp_id_ff;
   assign rsp_rem    = rsp_rem_ff;
   assign rsp_fin    = rsp_fin_ff;
   assign rsp_time   = rsp_time_ff;

endmodule

// File: src/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker
// port-level checks of the scheduler, bound to the top level
// ----------------------------------------------------------------------------
module pps_checker
   import pps_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // no result pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // one request in work at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // only a served slot reports a job
   a_no_job: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != RS_SERVED) |->
         (rsp_tdata[32:0] == 33'd0))
      else $error("job fields set on a non-served result");

   // a finished job has no burst left
   a_fin_rem: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> (rsp_tdata[31:16] == 16'd0))
      else $error("finished job with remaining burst");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the preemptive priority scheduler
// ----------------------------------------------------------------------------
// the bench keeps its own copy of the ready queue and the slot clock. It
// works out the expected result of every request at the moment that
// request's transfer is taken, and compares each result transfer field by
// field, in order. A short directed part covers these cases: idle slots,
// priority ties, a zero burst, preemption by a newly arrived job, and a full
// queue. After it comes a random mix of submits and ticks that keeps the
// queue moving between empty and full. The sender works in bursts with
// gaps. The receiver stalls in patterns of its own and once holds off long
// enough to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
   import pps_pkg::*;

   localparam int QUEUE_DEPTH  = 8;
   localparam int RANDOM_ITEMS = 580;
   localparam int LONG_HOLD    = 300;      // receiver hold-off, in cycles
   localparam int DRAIN_CYCLES = 20;       // extra wait once no result is awaited
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_REPORTS  = 40;

   // one expected result transfer
   typedef struct {
      status_type        status;
      logic [ID_W-1:0]    served_id;
      logic [BURST_W-1:0] remaining;
      logic               finished;
      logic [TIME_W-1:0]  end_time;
   } slot_result_type;

   // -------------------------------------------------------------------------
   // ready-queue predictor and store of awaited results
   // -------------------------------------------------------------------------
   class sched_scoreboard;
      logic [ID_W-1:0]    job_id   [QUEUE_DEPTH];
      logic [BURST_W-1:0] job_left [QUEUE_DEPTH];
      logic [PRIO_W-1:0]  job_prio [QUEUE_DEPTH];
      int                 job_count = 0;
      logic [TIME_W-1:0]  now_slot  = '0;
      slot_result_type    awaited[$];
      int errors = 0, checked = 0;
      int n_accepted = 0, n_rejected = 0, n_served = 0, n_finished = 0, n_idle = 0;

      // apply one accepted request to the queue copy and queue up its result
      function void note_request(action_type act, logic [ID_W-1:0] pid,
                                 logic [BURST_W-1:0] burst, logic [PRIO_W-1:0] prio);
         slot_result_type r;
         int pick, k;
         r.served_id = '0;
         r.remaining = '0;
         r.finished  = 1'b0;
         if (act == ACT_SUBMIT) begin
            if (job_count < QUEUE_DEPTH) begin
               job_id[job_count]   = pid;
               job_left[job_count] = burst;
               job_prio[job_count] = prio;
               job_count++;
               r.status = RS_ACCEPTED;
            end else begin
               r.status = RS_REJECTED;
            end
         end else if (job_count == 0) begin
            if (now_slot != '1) now_slot++;
            r.status = RS_IDLE;
         end else begin
            // strict less-than keeps the earliest queued job on a tie
            pick = 0;
            for (k = 1; k < job_count; k++)
               if (job_prio[k] < job_prio[pick]) pick = k;
            if (now_slot != '1) now_slot++;
            // a zero burst saturates, so it finishes like a burst of one
            if (job_left[pick] != '0) job_left[pick]--;
            r.status    = RS_SERVED;
            r.served_id = job_id[pick];
            r.remaining = job_left[pick];
            if (job_left[pick] == '0) begin
               r.finished = 1'b1;
               // close the gap, the rest keep arrival order
               for (k = pick; k < job_count - 1; k++) begin
                  job_id[k]   = job_id[k + 1];
                  job_left[k] = job_left[k + 1];
                  job_prio[k] = job_prio[k + 1];
               end
               job_count--;
            end
         end
         r.end_time = now_slot;
         awaited.push_back(r);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: result %0d field %s mismatch, expected %h actual %h",
                        $time, checked, field, want, got);
         end
      endfunction

      // compare one result transfer with the oldest expectation
      function void check_result(logic [1:0] status, logic [71:0] data);
         slot_result_type e;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: result with nothing expected, expected none actual %h/%h",
                        $time, status, data);
            return;
         end
         e = awaited.pop_front();
         checked++;
         compare("status",        e.status,    status);
         compare("served_id",     e.served_id, data[15:0]);
         compare("remaining",     e.remaining, data[31:16]);
         compare("finished",      e.finished,  data[32]);
         compare("slot_end_time", e.end_time,  data[64:33]);
         compare("zero fill",     '0,          data[71:65]);
         case (e.status)
            RS_ACCEPTED: n_accepted++;
            RS_REJECTED: n_rejected++;
            RS_SERVED: begin
               n_served++;
               if (e.finished) n_finished++;
            end
            default: n_idle++;
         endcase
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and the block
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // process_id[15:0], burst_length[31:16], priority_req[39:32]
   logic        req_tuser;    // action[0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;    // served_id[15:0], remaining[31:16], finished[32],
                              // slot_end_time[64:33], zero fill[71:65]
   logic [1:0]  rsp_tuser;    // status[1:0]

   sched_scoreboard sb = new;
   int  cycle_count = 0;
   int  burst_left  = 0;
   bit  hold_req    = 1'b0;   // sender asks the receiver for its long hold-off
   bit  hold_done   = 1'b0;

   always #10 clock = ~clock;

   preemptive_priority_scheduler #(.SLOTS(QUEUE_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d results outstanding",
                  $time, sb.awaited.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // result monitor, values seen as they stood before the edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tuser, rsp_tdata);
   end

   // receiver: stretches of steady, sparse, dense or toggling ready
   initial begin : rsp_pacer
      int span, mode;
      rsp_tready = 1'b0;
      forever begin
         if (hold_req && !hold_done) begin
            // long hold-off so the block fills and stops taking requests
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 80);
         repeat (span) begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ~rsp_tready;
            endcase
            @(posedge clock);
         end
      end
   end

   // offer one request and hold it until its transfer is taken
   task automatic send_request(input action_type act, input logic [ID_W-1:0] pid,
                               input logic [BURST_W-1:0] burst,
                               input logic [PRIO_W-1:0] prio);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {prio, burst, pid};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(act, pid, burst, prio);
      // sender bursts: at the end of one, maybe a gap before the next
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 9) >= 4) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      action_type         act;
      logic [ID_W-1:0]    pid;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      int                 pct, k;

      req_tvalid = 1'b0;
      req_tuser  = ACT_SUBMIT;
      req_tdata  = '0;
      reset      = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: idle slot on an empty queue
      send_request(ACT_TICK,   16'h0000, 16'h0000, 8'h00);
      // extreme ids and priorities, a zero burst, a tie on priority zero
      send_request(ACT_SUBMIT, 16'hFFFF, 16'h0001, 8'hFF);
      send_request(ACT_SUBMIT, 16'h0000, 16'h0000, 8'h00);
      send_request(ACT_SUBMIT, 16'h1234, 16'h0002, 8'h00);
      send_request(ACT_TICK,   16'h0000, 16'h0000, 8'h00);
      send_request(ACT_TICK,   16'h0000, 16'h0000, 8'h00);
      // a late arrival of middle priority cuts ahead of the 0xff job
      send_request(ACT_SUBMIT, 16'h5555, 16'h0001, 8'h80);
      repeat (4) send_request(ACT_TICK, 16'h0000, 16'h0000, 8'h00);
      // fill every slot, then one more that must bounce
      for (k = 0; k < QUEUE_DEPTH; k++)
         send_request(ACT_SUBMIT, 16'(16'h0100 + k), 16'(k % 2 + 1), 8'(k % 3));
      send_request(ACT_SUBMIT, 16'hAAAA, 16'hFFFF, 8'h00);
      send_request(ACT_TICK,   16'h0000, 16'h0000, 8'h00);
      send_request(ACT_TICK,   16'h0000, 16'h0000, 8'h00);

      // random: submit odds follow the queue level so it swings between empty and full
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 3) hold_req = 1'b1;
         if (sb.job_count == 0)                pct = 75;
         else if (sb.job_count == QUEUE_DEPTH) pct = 35;
         else if (sb.job_count >= 6)           pct = 30;
         else                                  pct = 45;
         act  = ($urandom_range(0, 99) < pct) ? ACT_SUBMIT : ACT_TICK;
         pid  = 16'($urandom_range(0, 16'hFFFF));
         prio = 8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255));
         // full-width bursts only go in when the submit bounces, so the queue never clogs
         if (sb.job_count == QUEUE_DEPTH)     burst = 16'($urandom_range(0, 16'hFFFF));
         else if ($urandom_range(0, 99) < 85) burst = 16'($urandom_range(0, 4));
         else                                 burst = 16'($urandom_range(5, 30));
         send_request(act, pid, burst, prio);
      end
      req_tvalid <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d results: %0d accepted, %0d rejected on a full queue,",
               sb.checked, sb.n_accepted, sb.n_rejected);
      $display("  %0d served slots of which %0d finished a job, %0d idle slots",
               sb.n_served, sb.n_finished, sb.n_idle);
      if (sb.errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
